// ===== hw/rtl/measurement_watchdog_fsm_macros.svh =====
// ----------------------------------------------------------------------------
// Measurement watchdog assertion macros
// Concurrent assertion wrappers used by the watchdog state machine RTL.
// ----------------------------------------------------------------------------
`ifndef MEASUREMENT_WATCHDOG_FSM_MACROS_SVH
`define MEASUREMENT_WATCHDOG_FSM_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MWD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked on the cycle after the trigger.
`define MWD_ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  `MWD_ASSERT(lbl, clk, rstn, (trig) |=> (cons), msg)

`endif

// ===== hw/rtl/mwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Measurement watchdog package
// Request and result types, configuration bundle, state codes and timeouts.
// ----------------------------------------------------------------------------
package mwd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [31:0] RespTimeoutRst = 32'd10000;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_VALUE    = 2'd1,
    FUNC_READ_CLR = 2'd2,
    FUNC_RESTART  = 2'd3
  } mwd_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBJ_PRESENT = 3'd0,
    CFG_OWN_OBJ_ID  = 3'd1,
    CFG_TMO_SELECT  = 3'd2,
    CFG_FB_MODE     = 3'd3,
    CFG_RESP_TMO    = 3'd4
  } mwd_cfg_idx_e;

  typedef enum logic [1:0] {
    FB_IGNORE     = 2'd0,
    FB_FALLBACK   = 2'd1,
    FB_REQ_IGNORE = 2'd2,
    FB_REQ_FB     = 2'd3
  } mwd_fb_mode_e;

  typedef enum logic [5:0] {
    ST_NOT_INIT  = 6'b000001,
    ST_INIT      = 6'b000010,
    ST_WAIT_RESP = 6'b000100,
    ST_WAIT_TMO  = 6'b001000,
    ST_FALLBACK  = 6'b010000,
    ST_IGNORE    = 6'b100000
  } mwd_state_e;

  localparam logic [2:0] CODE_NOT_INIT  = 3'd0;
  localparam logic [2:0] CODE_INIT      = 3'd1;
  localparam logic [2:0] CODE_WAIT_RESP = 3'd2;
  localparam logic [2:0] CODE_WAIT_TMO  = 3'd3;
  localparam logic [2:0] CODE_FALLBACK  = 3'd4;
  localparam logic [2:0] CODE_IGNORE    = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] current_millis;
    logic [15:0] object_id;
    logic        value_initialized;
  } mwd_req_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       request_read;
    logic       apply_fallback;
    logic       changed_flag;
  } mwd_res_t;

  typedef struct packed {
    logic        object_present;
    logic [15:0] own_object_id;
    logic [3:0]  timeout_select;
    logic [1:0]  fallback_mode;
    logic [31:0] response_timeout_ms;
  } mwd_cfg_t;

  function automatic logic [31:0] tmo_ms(logic [3:0] sel);
    logic [31:0] t;
    case (sel)
      4'd1:    t = 32'd600000;
      4'd2:    t = 32'd1800000;
      4'd3:    t = 32'd3600000;
      4'd4:    t = 32'd7200000;
      4'd5:    t = 32'd10800000;
      4'd6:    t = 32'd14400000;
      4'd7:    t = 32'd28800000;
      4'd8:    t = 32'd43200000;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] state_code(mwd_state_e s);
    logic [2:0] c;
    case (s)
      ST_NOT_INIT:  c = CODE_NOT_INIT;
      ST_INIT:      c = CODE_INIT;
      ST_WAIT_RESP: c = CODE_WAIT_RESP;
      ST_WAIT_TMO:  c = CODE_WAIT_TMO;
      ST_FALLBACK:  c = CODE_FALLBACK;
      ST_IGNORE:    c = CODE_IGNORE;
      default:      c = CODE_NOT_INIT;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/mwd_fsm.sv =====
// ----------------------------------------------------------------------------
// Measurement watchdog state machine
// Holds state, start time and changed flag; computes one result per request.
// ----------------------------------------------------------------------------
`include "measurement_watchdog_fsm_macros.svh"

module mwd_fsm import mwd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  mwd_req_t req_i,
  input  mwd_cfg_t cfg_i,
  output mwd_res_t res_o
);

  mwd_state_e  state_q, state_d;
  logic [31:0] start_q, start_d;
  logic        changed_q, changed_d;

  logic [31:0] tmo;
  logic        tmo_on;
  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;
  logic        take;
  logic        req_rd;
  logic        fb;

  always_comb begin
    tmo     = tmo_ms(cfg_i.timeout_select);
    tmo_on  = cfg_i.timeout_select inside {[4'd1:4'd8]};
    elapsed = req_i.current_millis - start_q;
    limit   = (state_q == ST_WAIT_RESP) ? cfg_i.response_timeout_ms : tmo;
    expired = tmo_on && (elapsed > limit);
  end

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    take    = 1'b0;
    req_rd  = 1'b0;
    fb      = 1'b0;
    case (req_i.func)
      FUNC_TICK: begin
        if (cfg_i.object_present) begin
          case (state_q)
            ST_INIT: begin
              start_d = req_i.current_millis;
              if (req_i.value_initialized) begin
                take = 1'b1;
              end else begin
                state_d = ST_WAIT_RESP;
                req_rd  = 1'b1;
              end
            end
            ST_WAIT_RESP: begin
              if (expired) begin
                if (cfg_i.fallback_mode inside {FB_FALLBACK, FB_REQ_FB}) begin
                  fb      = 1'b1;
                  state_d = ST_FALLBACK;
                end else begin
                  state_d = ST_IGNORE;
                end
              end
            end
            ST_WAIT_TMO: begin
              if (expired) begin
                if (cfg_i.fallback_mode inside {FB_REQ_IGNORE, FB_REQ_FB}) begin
                  req_rd  = 1'b1;
                  state_d = ST_WAIT_RESP;
                end else if (cfg_i.fallback_mode == FB_FALLBACK) begin
                  fb      = 1'b1;
                  state_d = ST_FALLBACK;
                end else begin
                  state_d = ST_IGNORE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      FUNC_VALUE: begin
        take = cfg_i.object_present && (req_i.object_id == cfg_i.own_object_id);
      end
      FUNC_RESTART: begin
        state_d = cfg_i.object_present ? ST_INIT : ST_IGNORE;
      end
      default: begin
      end
    endcase

    if (take) begin
      state_d = ST_WAIT_TMO;
      if (tmo_on) begin
        start_d = (req_i.current_millis == 32'd0) ? 32'd1 : req_i.current_millis;
      end
    end

    if (req_i.func == FUNC_READ_CLR) begin
      changed_d = 1'b0;
    end else begin
      changed_d = changed_q | take | (state_d != state_q);
    end

    res_o.state_code     = state_code(state_d);
    res_o.request_read   = req_rd;
    res_o.apply_fallback = fb;
    res_o.changed_flag   = (req_i.func == FUNC_READ_CLR) ? changed_q : changed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_NOT_INIT;
      start_q   <= 32'd0;
      changed_q <= 1'b0;
    end else if (fire_i) begin
      state_q   <= state_d;
      start_q   <= start_d;
      changed_q <= changed_d;
    end
  end

  `MWD_ASSERT(a_req_fb_excl, clk_i, rst_ni, !(fire_i && req_rd && fb), "read request and fallback together")
  `MWD_ASSERT_NEXT(a_fb_state, clk_i, rst_ni, fire_i && fb, state_q == ST_FALLBACK, "fallback without fallback state")
  `MWD_ASSERT_NEXT(a_chg_set, clk_i, rst_ni, fire_i && (state_d != state_q), changed_q, "state change left changed clear")
  `MWD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !fire_i, $stable(state_q) && $stable(changed_q), "state moved without request")

endmodule

// ===== hw/rtl/measurement_watchdog_fsm.sv =====
// ----------------------------------------------------------------------------
// Measurement watchdog
// Tracks freshness of one measured value and raises read or fallback pulses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------
//  in      | input     | in_valid_i/in_stall_o | in_req_i  (mwd_req_t)
//  out     | output    | out_valid_o/out_stall_i | out_req_o (mwd_res_t)
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  One request per cycle unless the output stalls; a request passes
//  the input register, then the state update into the result register.
//  Reset clears state, start time and changed flag, and loads the
//  configuration defaults.
//  A stalled result holds the input register; the input stalls only when
//  both registers are full.
// ----------------------------------------------------------------------------
module measurement_watchdog_fsm import mwd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mwd_req_t            in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mwd_res_t            out_req_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  mwd_cfg_t cfg_q;
  logic     s1_valid_q;
  mwd_req_t s1_q;
  logic     out_valid_q;
  mwd_res_t out_q;
  mwd_res_t res;
  logic     s1_hold;
  logic     s1_fire;
  logic     in_fire;

  assign s1_hold    = out_valid_q && out_stall_i;
  assign s1_fire    = s1_valid_q && !s1_hold;
  assign in_stall_o = s1_valid_q && s1_hold;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.object_present      <= 1'b0;
      cfg_q.own_object_id       <= 16'd0;
      cfg_q.timeout_select      <= 4'd0;
      cfg_q.fallback_mode       <= 2'd0;
      cfg_q.response_timeout_ms <= RespTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OBJ_PRESENT: cfg_q.object_present      <= cfg_wdata_i[0];
        CFG_OWN_OBJ_ID:  cfg_q.own_object_id       <= cfg_wdata_i[15:0];
        CFG_TMO_SELECT:  cfg_q.timeout_select      <= cfg_wdata_i[3:0];
        CFG_FB_MODE:     cfg_q.fallback_mode       <= cfg_wdata_i[1:0];
        CFG_RESP_TMO:    cfg_q.response_timeout_ms <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_req_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  mwd_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .req_i  (s1_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== tb/sv/mwd_result_checker.sv =====
// ----------------------------------------------------------------------------
// Measurement watchdog result checker
// Watches the configuration port and both the request and result channels, keeps its own
// copy of the watchdog state and registers, predicts the result of every
// accepted request and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module mwd_result_checker import mwd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mwd_req_t            in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mwd_res_t            out_res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  error_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  mwd_cfg_t    regs;
  logic [2:0]  fsm_code;
  logic [31:0] start_ms;
  logic        changed;
  mwd_res_t    expected_results[$];
  int          errors;

  function automatic logic [31:0] timeout_for(logic [3:0] sel);
    case (sel)
      4'd1:    return 10 * 60 * 1000;
      4'd2:    return 30 * 60 * 1000;
      4'd3:    return 60 * 60 * 1000;
      4'd4:    return 2 * 60 * 60 * 1000;
      4'd5:    return 3 * 60 * 60 * 1000;
      4'd6:    return 4 * 60 * 60 * 1000;
      4'd7:    return 8 * 60 * 60 * 1000;
      4'd8:    return 12 * 60 * 60 * 1000;
      default: return 32'd0;
    endcase
  endfunction

  function automatic void enter_state(logic [2:0] code);
    if (fsm_code != code) begin
      fsm_code = code;
      changed = 1'b1;
    end
  endfunction

  function automatic void take_value(logic [31:0] now_ms, logic [31:0] limit_ms);
    enter_state(CODE_WAIT_TMO);
    changed = 1'b1;
    if (limit_ms != 0) start_ms = (now_ms == 0) ? 32'd1 : now_ms;
  endfunction

  function automatic void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_OBJ_PRESENT: regs.object_present = data[0];
      CFG_OWN_OBJ_ID:  regs.own_object_id = data[15:0];
      CFG_TMO_SELECT:  regs.timeout_select = data[3:0];
      CFG_FB_MODE:     regs.fallback_mode = data[1:0];
      CFG_RESP_TMO:    regs.response_timeout_ms = data;
      default: ;
    endcase
  endfunction

  function automatic mwd_res_t watchdog_step(mwd_req_t r);
    logic [31:0] limit_ms;
    logic [31:0] elapsed;
    mwd_res_t    res;
    limit_ms = timeout_for(regs.timeout_select);
    elapsed = r.current_millis - start_ms;
    res = '0;
    case (r.func)
      FUNC_TICK: begin
        if (regs.object_present) begin
          case (fsm_code)
            CODE_INIT: begin
              start_ms = r.current_millis;
              if (r.value_initialized) begin
                take_value(r.current_millis, limit_ms);
              end else begin
                enter_state(CODE_WAIT_RESP);
                res.request_read = 1'b1;
              end
            end
            CODE_WAIT_RESP: begin
              if (limit_ms != 0 && elapsed > regs.response_timeout_ms) begin
                if (regs.fallback_mode == FB_FALLBACK || regs.fallback_mode == FB_REQ_FB) begin
                  res.apply_fallback = 1'b1;
                  enter_state(CODE_FALLBACK);
                end else begin
                  enter_state(CODE_IGNORE);
                end
              end
            end
            CODE_WAIT_TMO: begin
              if (limit_ms != 0 && elapsed > limit_ms) begin
                if (regs.fallback_mode == FB_REQ_IGNORE || regs.fallback_mode == FB_REQ_FB) begin
                  res.request_read = 1'b1;
                  enter_state(CODE_WAIT_RESP);
                end else if (regs.fallback_mode == FB_FALLBACK) begin
                  res.apply_fallback = 1'b1;
                  enter_state(CODE_FALLBACK);
                end else begin
                  enter_state(CODE_IGNORE);
                end
              end
            end
            default: ;
          endcase
        end
        res.changed_flag = changed;
      end
      FUNC_VALUE: begin
        if (regs.object_present && r.object_id == regs.own_object_id) begin
          take_value(r.current_millis, limit_ms);
        end
        res.changed_flag = changed;
      end
      FUNC_READ_CLR: begin
        res.changed_flag = changed;
        changed = 1'b0;
      end
      FUNC_RESTART: begin
        enter_state(regs.object_present ? CODE_INIT : CODE_IGNORE);
        res.changed_flag = changed;
      end
      default: ;
    endcase
    res.state_code = fsm_code;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [2:0] want_v,
                             input logic [2:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mwd_res_t want;
    if (!rst_ni) begin
      regs = '0;
      regs.response_timeout_ms = RespTimeoutRst;
      fsm_code = CODE_NOT_INIT;
      start_ms = '0;
      changed = 1'b0;
      expected_results.delete();
      errors = 0;
      pending_o <= 0;
      error_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: state_code %0d, request_read %0b, apply_fallback %0b",
                 out_res_i.state_code, out_res_i.request_read, out_res_i.apply_fallback);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("state_code", want.state_code, out_res_i.state_code);
          check_field("request_read", want.request_read, out_res_i.request_read);
          check_field("apply_fallback", want.apply_fallback, out_res_i.apply_fallback);
          check_field("changed_flag", want.changed_flag, out_res_i.changed_flag);
        end
      end
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) expected_results.push_back(watchdog_step(in_req_i));
      pending_o <= expected_results.size();
      error_count_o <= errors;
    end
  end

endmodule

// ===== tb/sv/measurement_watchdog_fsm_test.sv =====
// ----------------------------------------------------------------------------
// Measurement watchdog testbench
// Drives a directed sequence through every operation and several timeout paths, then
// random phases of well-formed watchdog traffic with random idling on both
// channels and a long output hold-off; the checker reports any mismatch.
// ----------------------------------------------------------------------------
module measurement_watchdog_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mwd_pkg::*;

  localparam time CLK_PERIOD       = 10ns;
  localparam int  RESET_CYCLES     = 7;
  localparam int  DRAIN_CYCLES     = 4;
  localparam int  LONG_HOLD_CYCLES = 80;
  localparam int  PHASES           = 8;
  localparam int  ITEMS_PER_PHASE  = 115;
  localparam int  BURST_ITEMS      = 24;
  localparam time RUN_LIMIT        = 5ms;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mwd_req_t            in_req = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mwd_res_t            out_res;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int                  error_count;
  int                  pending;
  bit                  hold_off_pending = 1'b0;
  bit                  holding = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  measurement_watchdog_fsm u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mwd_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_res_i     (out_res),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic mwd_req_t request(mwd_func_e func, logic [31:0] now_ms,
                                       logic [15:0] id, logic vinit);
    mwd_req_t r;
    r.func = func;
    r.current_millis = now_ms;
    r.object_id = id;
    r.value_initialized = vinit;
    return r;
  endfunction

  function automatic mwd_cfg_t random_settings();
    mwd_cfg_t c;
    c.object_present = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0:       c.own_object_id = 16'h0000;
      1:       c.own_object_id = 16'hFFFF;
      default: c.own_object_id = 16'($urandom);
    endcase
    c.timeout_select = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    c.fallback_mode = 2'($urandom);
    case ($urandom_range(0, 3))
      0:       c.response_timeout_ms = 32'd0;
      1:       c.response_timeout_ms = 32'hFFFF_FFFF;
      2:       c.response_timeout_ms = $urandom_range(1, 5000);
      default: c.response_timeout_ms = $urandom_range(1, 20_000_000);
    endcase
    return c;
  endfunction

  function automatic mwd_req_t random_request(input mwd_cfg_t c, inout logic [31:0] now_ms);
    mwd_req_t r;
    int       roll;
    r = request(FUNC_TICK, now_ms, c.own_object_id, 1'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.func = FUNC_RESTART;
    end else if (roll < 60) begin
      case ($urandom_range(0, 9))
        0, 1, 2: now_ms += $urandom_range(0, 100);
        3, 4:    now_ms += $urandom_range(0, c.response_timeout_ms);
        5, 6, 7: now_ms += $urandom_range(0, 15_000_000);
        8:       now_ms += $urandom_range(0, 45_000_000);
        default: now_ms += $urandom;
      endcase
      r.current_millis = now_ms;
    end else if (roll < 75) begin
      r.func = FUNC_VALUE;
      if ($urandom_range(0, 4) == 0) r.object_id = 16'($urandom);
    end else if (roll < 88) begin
      r.func = FUNC_READ_CLR;
    end else begin
      r.func = mwd_func_e'(2'($urandom));
      r.current_millis = $urandom;
      r.object_id = 16'($urandom);
    end
    return r;
  endfunction

  // Hold valid until accepted; a zero gap leaves valid high for the next request.
  task automatic send(input mwd_req_t r, input int gap);
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mwd_cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input mwd_cfg_t c);
    write_reg(CFG_OBJ_PRESENT, CfgDataW'(c.object_present));
    write_reg(CFG_OWN_OBJ_ID, CfgDataW'(c.own_object_id));
    write_reg(CFG_TMO_SELECT, CfgDataW'(c.timeout_select));
    write_reg(CFG_FB_MODE, CfgDataW'(c.fallback_mode));
    write_reg(CFG_RESP_TMO, c.response_timeout_ms);
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int run;
    wait (rst_n);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run = pick_gap();
        repeat (run + 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    mwd_cfg_t    setting;
    logic [31:0] now_ms;
    bit          gapless;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // object absent after reset
    send(request(FUNC_RESTART, 32'd0, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b1), pick_gap());
    send(request(FUNC_VALUE, 32'd7, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_READ_CLR, 32'd0, 16'hFFFF, 1'b0), pick_gap());
    drain();

    setting = '{object_present: 1'b1, own_object_id: 16'hFFFF, timeout_select: 4'd1,
                fallback_mode: FB_REQ_FB, response_timeout_ms: 32'd1000};
    load_settings(setting);
    send(request(FUNC_VALUE, 32'd0, 16'hFFFF, 1'b0), pick_gap());
    send(request(FUNC_READ_CLR, 32'd0, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_RESTART, 32'd5, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'd100, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'd1100, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'd1101, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_RESTART, 32'd0, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'hFFFF_FF00, 16'h0000, 1'b1), pick_gap());
    send(request(FUNC_TICK, 32'hFFFF_FF00 + 32'd600001, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_VALUE, 32'd42, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_VALUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0), pick_gap());
    send(request(FUNC_READ_CLR, 32'd0, 16'h0000, 1'b0), pick_gap());
    drain();

    setting = '{object_present: 1'b1, own_object_id: 16'h0000, timeout_select: 4'd15,
                fallback_mode: FB_IGNORE, response_timeout_ms: 32'd0};
    load_settings(setting);
    send(request(FUNC_RESTART, 32'd0, 16'h0000, 1'b0), 0);
    send(request(FUNC_TICK, 32'd3, 16'h0000, 1'b0), 0);
    send(request(FUNC_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0), 0);
    send(request(FUNC_VALUE, 32'd0, 16'h0000, 1'b0), 0);
    send(request(FUNC_TICK, 32'h8000_0000, 16'h0000, 1'b0), 0);
    drain();

    setting = '{object_present: 1'b1, own_object_id: 16'h5A5A, timeout_select: 4'd8,
                fallback_mode: FB_IGNORE, response_timeout_ms: 32'd0};
    load_settings(setting);
    send(request(FUNC_RESTART, 32'd0, 16'h0000, 1'b0), pick_gap());
    send(request(FUNC_TICK, 32'd0, 16'h0000, 1'b1), pick_gap());
    send(request(FUNC_TICK, 32'd43_200_002, 16'h0000, 1'b0), pick_gap());
    drain();

    now_ms = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      setting = random_settings();
      case (p)
        0: setting.fallback_mode = FB_FALLBACK;
        1: begin
          setting.fallback_mode = FB_REQ_IGNORE;
          setting.response_timeout_ms = 32'hFFFF_FFFF;
        end
        2: setting.timeout_select = 4'd0;
        default: ;
      endcase
      load_settings(setting);
      gapless = ($urandom_range(0, 3) == 0);
      if (p == 3) begin
        // fill the block while the receiver holds off
        hold_off_pending = 1'b1;
        wait (holding);
        for (int i = 0; i < BURST_ITEMS; i++) send(random_request(setting, now_ms), 0);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send(random_request(setting, now_ms), gapless ? 0 : pick_gap());
      end
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mwd_pkg.sv
hw/rtl/mwd_fsm.sv
hw/rtl/measurement_watchdog_fsm.sv
tb/sv/mwd_result_checker.sv
tb/sv/measurement_watchdog_fsm_test.sv
